@@ rtl/edh_pkg.sv @@
// shared types, constants and helpers for the error diffusion halftone block
// no dependencies; used by edh_line_buf, edh_diffuse and error_diffusion_halftone
`default_nettype none

package edh_pkg;

    localparam int PIX_W    = 8;   // grey level width
    localparam int ERR_W    = 8;   // stored diffused error, signed
    localparam int LW_W     = 11;  // line_width register width
    localparam int FH_W     = 16;  // frame_height register width
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 11'd1024;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    localparam logic [PIX_W-1:0] THRESHOLD = 8'd127;
    localparam logic [PIX_W-1:0] WHITE_LVL = 8'd255;

    // position flags of one pixel, computed at acceptance
    typedef struct packed {
        logic first_row;
        logic last_col;
        logic last_row;
        logic col_zero;
    } t_pos_tag;

    // signed divide by 16, truncating toward zero
    function automatic logic signed [ERR_W-1:0] f_trunc16(input logic signed [11:0] t);
        logic signed [11:0] b;
        b = t + (t[11] ? 12'sd15 : 12'sd0);
        return b[11:4];
    endfunction

endpackage

`default_nettype wire

@@ rtl/edh_line_buf.sv @@
// line memory holding the finished error of each column for the next row
// one read and one write a cycle, a deferred-write slot and read forwarding; uses edh_pkg
`default_nettype none

module edh_line_buf #(
    parameter int MAX_LINE = 1024,
    parameter int AW       = 10
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_rd_en,
    input  wire  [AW-1:0]                       i_rd_addr,
    output logic signed [edh_pkg::ERR_W-1:0]    o_rd_data,
    input  wire                                 i_wa_en,
    input  wire  [AW-1:0]                       i_wa_addr,
    input  wire  signed [edh_pkg::ERR_W-1:0]    i_wa_data,
    input  wire                                 i_wb_en,
    input  wire  [AW-1:0]                       i_wb_addr,
    input  wire  signed [edh_pkg::ERR_W-1:0]    i_wb_data
);

    logic signed [edh_pkg::ERR_W-1:0] mem [MAX_LINE];

    logic signed [edh_pkg::ERR_W-1:0] r_rd;
    logic                             r_byp_v;
    logic signed [edh_pkg::ERR_W-1:0] r_byp_d;
    logic                             r_pend_v;
    logic [AW-1:0]                    r_pend_a;
    logic signed [edh_pkg::ERR_W-1:0] r_pend_d;

    logic                             we;
    logic [AW-1:0]                    wa;
    logic signed [edh_pkg::ERR_W-1:0] wd;

    // port priority: left-column write, then last-column write, then deferred slot
    always_comb begin
        we = 1'b1;
        wa = r_pend_a;
        wd = r_pend_d;
        if (i_wa_en) begin
            wa = i_wa_addr;
            wd = i_wa_data;
        end else if (i_wb_en) begin
            wa = i_wb_addr;
            wd = i_wb_data;
        end else if (!r_pend_v) begin
            we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (i_rd_en) begin
            r_rd    <= mem[i_rd_addr];
            r_byp_d <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_byp_v  <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_byp_v <= we && (wa == i_rd_addr);
            end
            if (i_wa_en && i_wb_en) begin
                r_pend_v <= 1'b1;
            end else if (!i_wa_en && !i_wb_en) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wa_en && i_wb_en) begin
            r_pend_a <= i_wb_addr;
            r_pend_d <= i_wb_data;
        end
    end

    assign o_rd_data = r_byp_v ? r_byp_d : r_rd;

    a_no_pend_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wa_en && i_wb_en) |-> !r_pend_v)
        else $error("deferred write slot overwritten before drain");

    a_pend_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && !i_wa_en && !i_wb_en) |=> !r_pend_v)
        else $error("deferred write not drained on a free port cycle");

endmodule

`default_nettype wire

@@ rtl/edh_diffuse.sv @@
// error stage: adds diffused error, thresholds, spreads 7/16 5/16 3/16 1/16
// holds the right carry and the two partial sums for the next row; uses edh_pkg
`default_nettype none

module edh_diffuse #(
    parameter int AW = 10
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_adv,
    input  wire  [edh_pkg::PIX_W-1:0]           i_pix,
    input  edh_pkg::t_pos_tag                   i_tag,
    input  wire  [AW-1:0]                       i_col,
    input  wire  signed [edh_pkg::ERR_W-1:0]    i_above,
    output logic                                o_white,
    output logic                                o_wa_en,
    output logic [AW-1:0]                       o_wa_addr,
    output logic signed [edh_pkg::ERR_W-1:0]    o_wa_data,
    output logic                                o_wb_en,
    output logic [AW-1:0]                       o_wb_addr,
    output logic signed [edh_pkg::ERR_W-1:0]    o_wb_data
);

    logic signed [edh_pkg::ERR_W-1:0] r_carry, n_carry;
    logic signed [edh_pkg::ERR_W-1:0] r_prev, n_prev;
    logic signed [edh_pkg::ERR_W-1:0] r_cur, n_cur;

    logic signed [edh_pkg::ERR_W-1:0] above;
    logic signed [10:0]               sum;
    logic [edh_pkg::PIX_W-1:0]        sat;
    logic signed [8:0]                err;
    logic signed [11:0]               e12;
    logic signed [edh_pkg::ERR_W-1:0] q7, q5, q3, q1;

    always_comb begin
        above = i_tag.first_row ? '0 : i_above;
        sum = $signed({3'b000, i_pix}) + 11'(above) + 11'(r_carry);
        if (sum[10]) begin
            sat = '0;
        end else if (sum > 11'sd255) begin
            sat = edh_pkg::WHITE_LVL;
        end else begin
            sat = sum[7:0];
        end
        o_white = (sat > edh_pkg::THRESHOLD);
        err = o_white ? $signed({1'b0, sat}) - $signed({1'b0, edh_pkg::WHITE_LVL})
                      : $signed({1'b0, sat});
        e12 = 12'(err);
        q7 = edh_pkg::f_trunc16((e12 <<< 3) - e12);
        q5 = edh_pkg::f_trunc16((e12 <<< 2) + e12);
        q3 = edh_pkg::f_trunc16((e12 <<< 1) + e12);
        q1 = edh_pkg::f_trunc16(e12);

        n_carry = i_tag.last_col ? '0 : q7;
        if (i_tag.last_col) begin
            n_prev = '0;
            n_cur  = '0;
        end else begin
            n_prev = r_cur + q5;
            n_cur  = q1;
        end

        o_wa_en   = i_adv && !i_tag.col_zero;
        o_wa_addr = i_col - AW'(1);
        o_wa_data = r_prev + q3;
        o_wb_en   = i_adv && i_tag.last_col;
        o_wb_addr = i_col;
        o_wb_data = r_cur + q5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_prev  <= '0;
            r_cur   <= '0;
        end else if (i_adv) begin
            r_carry <= n_carry;
            r_prev  <= n_prev;
            r_cur   <= n_cur;
        end
    end

endmodule

`default_nettype wire

@@ rtl/error_diffusion_halftone.sv @@
// an accepted pixel sits in the error stage register with its line memory read, then its dot
// is registered at the output; throughput: one pixel per clock unless the dot side stalls,
// bounded by the right-carry loop and by one read plus one write per cycle on the line memory
// reset: synchronous active low; clears counters, carries and handshake state; the line
// memory is not cleared, since the first row of a frame ignores what it reads from it
// top level of the error diffusion halftone block; uses edh_pkg, edh_line_buf, edh_diffuse
`default_nettype none

module error_diffusion_halftone #(
    parameter int MAX_LINE = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // pixel input channel
    input  wire                                i_pix_valid,
    output logic                               o_pix_stall,
    input  wire  [edh_pkg::PIX_W-1:0]          i_grey_pixel,
    // dot output channel
    output logic                               o_dot_valid,
    input  wire                                i_dot_stall,
    output logic                               o_white_dot,
    output logic                               o_row_end,
    output logic                               o_frame_end,
    // configuration write channel
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [edh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [edh_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_LINE);
    // compare width: holds the register value and MAX_LINE itself
    localparam int CW = (AW + 1 > edh_pkg::LW_W) ? AW + 1 : edh_pkg::LW_W;
    localparam int RW = edh_pkg::FH_W + 1;

    // configuration registers
    logic [edh_pkg::LW_W-1:0] r_line_width;
    logic [edh_pkg::FH_W-1:0] r_frame_height;

    // raster position of the next pixel
    logic [AW-1:0]            r_col, n_col;
    logic [edh_pkg::FH_W-1:0] r_row, n_row;

    // error stage holding register
    logic                      r_s1_v;
    logic [edh_pkg::PIX_W-1:0] r_s1_pix;
    edh_pkg::t_pos_tag         r_s1_tag;
    logic [AW-1:0]             r_s1_col;

    // output register
    logic r_out_v;
    logic r_out_white;
    logic r_out_row;
    logic r_out_frame;

    logic              in_acc;
    logic              s1_adv;
    logic [CW-1:0]     w_eff;
    logic [CW-1:0]     col_p1;
    logic [RW-1:0]     h_eff;
    logic [RW-1:0]     row_p1;
    edh_pkg::t_pos_tag tag;

    logic signed [edh_pkg::ERR_W-1:0] above;
    logic                             white;
    logic                             wa_en, wb_en;
    logic [AW-1:0]                    wa_addr, wb_addr;
    logic signed [edh_pkg::ERR_W-1:0] wa_data, wb_data;

    // handshake: the error stage moves on when the output register is free or draining
    assign s1_adv      = r_s1_v && (!r_out_v || !i_dot_stall);
    assign o_pix_stall = r_s1_v && !s1_adv;
    assign in_acc      = i_pix_valid && !o_pix_stall;
    assign o_cfg_ready = 1'b1;

    // effective size: zero counts as one, width saturates at the buffer depth
    always_comb begin
        w_eff = CW'(r_line_width);
        if (r_line_width == '0) begin
            w_eff = CW'(1);
        end else if (w_eff > CW'(MAX_LINE)) begin
            w_eff = CW'(MAX_LINE);
        end
        h_eff = (r_frame_height == '0) ? RW'(1) : RW'(r_frame_height);
        col_p1 = CW'(r_col) + CW'(1);
        row_p1 = RW'(r_row) + RW'(1);

        tag.first_row = (r_row == '0);
        tag.last_col  = (col_p1 >= w_eff);
        tag.last_row  = (row_p1 >= h_eff);
        tag.col_zero  = (r_col == '0);

        // a position at or past the last column wraps to the next row, or to row zero after the last row
        n_col = tag.last_col ? '0 : col_p1[AW-1:0];
        n_row = r_row;
        if (tag.last_col) begin
            n_row = tag.last_row ? '0 : row_p1[edh_pkg::FH_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= edh_pkg::LINE_WIDTH_RST;
            r_frame_height <= edh_pkg::FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_v         <= 1'b0;
            r_out_v        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    edh_pkg::CFG_LINE_WIDTH: begin
                        r_line_width <= i_cfg_data[edh_pkg::LW_W-1:0];
                    end
                    edh_pkg::CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data[edh_pkg::FH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
            end else if (!i_dot_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= i_grey_pixel;
            r_s1_tag <= tag;
            r_s1_col <= r_col;
        end
        if (s1_adv) begin
            r_out_white <= white;
            r_out_row   <= r_s1_tag.last_col;
            r_out_frame <= r_s1_tag.last_col && r_s1_tag.last_row;
        end
    end

    // line memory: read issued at acceptance, data lands with the error stage
    edh_line_buf #(
        .MAX_LINE (MAX_LINE),
        .AW       (AW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (above),
        .i_wa_en   (wa_en),
        .i_wa_addr (wa_addr),
        .i_wa_data (wa_data),
        .i_wb_en   (wb_en),
        .i_wb_addr (wb_addr),
        .i_wb_data (wb_data)
    );

    edh_diffuse #(
        .AW (AW)
    ) u_diffuse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (s1_adv),
        .i_pix     (r_s1_pix),
        .i_tag     (r_s1_tag),
        .i_col     (r_s1_col),
        .i_above   (above),
        .o_white   (white),
        .o_wa_en   (wa_en),
        .o_wa_addr (wa_addr),
        .o_wa_data (wa_data),
        .o_wb_en   (wb_en),
        .o_wb_addr (wb_addr),
        .o_wb_data (wb_data)
    );

    assign o_dot_valid = r_out_v;
    assign o_white_dot = r_out_white;
    assign o_row_end   = r_out_row;
    assign o_frame_end = r_out_frame;

    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_frame) |-> r_out_row)
        else $error("frame end without row end");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_col) < CW'(MAX_LINE))
        else $error("column counter beyond line memory");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_v)
        else $error("accepted pixel lost before error stage");

    a_held_dot_keeps_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_dot_stall && r_s1_v) |=> r_s1_v)
        else $error("error stage advanced into a stalled output");

endmodule

`default_nettype wire

@@ test/error_diffusion_halftone_check.sv @@
`timescale 1ns / 100ps
// checker for error_diffusion_halftone: watches the pixel, dot and register channels,
// predicts every dot from its own copy of the diffusion state and compares in order
// depends on edh_pkg for field widths, register indexes and levels

module error_diffusion_halftone_check #(
    parameter int MAX_LINE = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_pix_valid,
    input  wire                              i_pix_stall,
    input  wire  [edh_pkg::PIX_W-1:0]        i_grey_pixel,
    input  wire                              i_dot_valid,
    input  wire                              i_dot_stall,
    input  wire                              i_white_dot,
    input  wire                              i_row_end,
    input  wire                              i_frame_end,
    input  wire                              i_cfg_valid,
    input  wire                              i_cfg_ready,
    input  wire  [edh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [edh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_dot_count
);

    localparam int PIX_W = edh_pkg::PIX_W;
    localparam int ERR_W = edh_pkg::ERR_W;
    localparam int LW_W  = edh_pkg::LW_W;
    localparam int FH_W  = edh_pkg::FH_W;

    typedef struct packed {
        logic white;
        logic row_end;
        logic frame_end;
    } t_dot;

    logic [LW_W-1:0]         width_reg;
    logic [FH_W-1:0]         height_reg;
    logic signed [ERR_W-1:0] below_err [MAX_LINE];
    logic signed [ERR_W-1:0] carry_right;
    logic signed [ERR_W-1:0] below_left_acc;
    logic signed [ERR_W-1:0] below_here_acc;
    int                      col;
    int                      row;
    t_dot                    dots_due [$];

    // one pixel through the ditherer, updating the error state
    function automatic t_dot halftone_pixel(input logic [PIX_W-1:0] grey);
        int   w;
        int   h;
        int   above;
        int   level;
        int   err;
        logic last_col;
        logic last_row;
        t_dot d;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_LINE) ? MAX_LINE : int'(width_reg);
        h = (height_reg == 0) ? 1 : int'(height_reg);
        last_col = (col + 1 >= w);
        last_row = (row + 1 >= h);
        above = (row != 0 && col < MAX_LINE) ? int'(below_err[col]) : 0;
        level = int'(grey) + above + int'(carry_right);
        if (level < 0) level = 0;
        if (level > int'(edh_pkg::WHITE_LVL)) level = int'(edh_pkg::WHITE_LVL);
        d.white = (level > int'(edh_pkg::THRESHOLD));
        err = level - (d.white ? int'(edh_pkg::WHITE_LVL) : 0);
        carry_right = last_col ? '0 : ERR_W'(err * 7 / 16);
        if (col > 0 && col - 1 < MAX_LINE)
            below_err[col - 1] = ERR_W'(int'(below_left_acc) + err * 3 / 16);
        if (last_col) begin
            if (col < MAX_LINE)
                below_err[col] = ERR_W'(int'(below_here_acc) + err * 5 / 16);
            below_left_acc = '0;
            below_here_acc = '0;
            col = 0;
            row = last_row ? 0 : ((row + 1) & 16'hFFFF);
        end else begin
            below_left_acc = ERR_W'(int'(below_here_acc) + err * 5 / 16);
            below_here_acc = ERR_W'(err / 16);
            col = col + 1;
        end
        d.row_end = last_col;
        d.frame_end = last_col && last_row;
        return d;
    endfunction

    always @(posedge i_clk) begin : watch
        t_dot want;
        if (!i_rst_n) begin
            width_reg = edh_pkg::LINE_WIDTH_RST;
            height_reg = edh_pkg::FRAME_HEIGHT_RST;
            foreach (below_err[k]) below_err[k] = '0;
            carry_right = '0;
            below_left_acc = '0;
            below_here_acc = '0;
            col = 0;
            row = 0;
            dots_due.delete();
            o_fail_count = 0;
            o_dot_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    edh_pkg::CFG_LINE_WIDTH:   width_reg = i_cfg_data[LW_W-1:0];
                    edh_pkg::CFG_FRAME_HEIGHT: height_reg = i_cfg_data[FH_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && !i_pix_stall)
                dots_due.push_back(halftone_pixel(i_grey_pixel));
            if (i_dot_valid && !i_dot_stall) begin
                o_dot_count++;
                if (dots_due.size() == 0) begin
                    $error("dot transaction with no pixel waiting for it");
                    o_fail_count++;
                end else begin
                    want = dots_due.pop_front();
                    if (i_white_dot !== want.white) begin
                        $error("white_dot: expected %0d, actual %0d", want.white, i_white_dot);
                        o_fail_count++;
                    end
                    if (i_row_end !== want.row_end) begin
                        $error("row_end: expected %0d, actual %0d", want.row_end, i_row_end);
                        o_fail_count++;
                    end
                    if (i_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d", want.frame_end,
                               i_frame_end);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = dots_due.size();
    end

endmodule

@@ test/error_diffusion_halftone_test.sv @@
`timescale 1ns / 100ps
// top of the error_diffusion_halftone testbench: clock, reset, pixel and register stimulus
// depends on edh_pkg, the block and error_diffusion_halftone_check, which does the checking

module error_diffusion_halftone_test;

    localparam int PIX_W      = edh_pkg::PIX_W;
    localparam int CFG_IDX_W  = edh_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = edh_pkg::CFG_DATA_W;

    localparam int MAX_LINE     = 1024;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 400_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    logic [PIX_W-1:0]      grey = '0;
    logic                  dot_valid;
    logic                  dot_stall = 1'b0;
    logic                  white_dot;
    logic                  row_end;
    logic                  frame_end;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = edh_pkg::CFG_LINE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int dot_count;
    int cycle_count = 0;
    int send_idle_pct = 0;   // chance per cycle that the pixel side holds off
    int stall_pct = 0;       // chance per cycle that the dot side stalls

    // grey levels around the threshold and at the rails
    logic [PIX_W-1:0] extreme_greys [4] = '{8'd0, 8'd255, 8'd127, 8'd128};
    // pushes the sum past both clamps and mixes black and white errors
    logic [PIX_W-1:0] clamp_greys [13] = '{8'd127, 8'd250, 8'd128, 8'd5, 8'd0, 8'd255,
                                           8'd127, 8'd128, 8'd200, 8'd40, 8'd255, 8'd0,
                                           8'd127};

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    error_diffusion_halftone #(
        .MAX_LINE(MAX_LINE)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix_valid  (pix_valid),
        .o_pix_stall  (pix_stall),
        .i_grey_pixel (grey),
        .o_dot_valid  (dot_valid),
        .i_dot_stall  (dot_stall),
        .o_white_dot  (white_dot),
        .o_row_end    (row_end),
        .o_frame_end  (frame_end),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    error_diffusion_halftone_check #(
        .MAX_LINE(MAX_LINE)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix_valid  (pix_valid),
        .i_pix_stall  (pix_stall),
        .i_grey_pixel (grey),
        .i_dot_valid  (dot_valid),
        .i_dot_stall  (dot_stall),
        .i_white_dot  (white_dot),
        .i_row_end    (row_end),
        .i_frame_end  (frame_end),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_dot_count  (dot_count)
    );

    // dot side back-pressure, redrawn every cycle
    always @(negedge clk) begin
        dot_stall <= ($urandom_range(99) < stall_pct);
    end

    // hard stop in case the block hangs
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d dots still due", cycle_count, pending);
            $display("[error_diffusion_halftone] ERROR");
            $finish;
        end
    end

    // one pixel transaction; entered and left at a falling edge
    // valid stays high afterwards so back-to-back pixels never drop it
    task automatic push_pixel(input logic [PIX_W-1:0] g);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        grey <= g;
        do @(posedge clk); while (pix_stall);
        @(negedge clk);
    endtask

    // stop sending and let every predicted dot come out
    task automatic drain_dots();
        pix_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // one register transaction, valid left high for a following write
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // single write once the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        drain_dots();
        cfg_put(idx, d);
        cfg_valid <= 1'b0;
    endtask

    // both geometry registers, in random order, once the block is idle
    task automatic program_geometry(input logic [CFG_DATA_W-1:0] w,
                                    input logic [CFG_DATA_W-1:0] h);
        drain_dots();
        if ($urandom_range(1)) begin
            cfg_put(edh_pkg::CFG_LINE_WIDTH, w);
            cfg_put(edh_pkg::CFG_FRAME_HEIGHT, h);
        end else begin
            cfg_put(edh_pkg::CFG_FRAME_HEIGHT, h);
            cfg_put(edh_pkg::CFG_LINE_WIDTH, w);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int               weff;
        int               heff;
        int               frames;
        int               style;
        int               base;
        int               total;
        int               phase;
        int               small_sent;
        logic [15:0]      w_data;
        logic [15:0]      h_data;
        logic [PIX_W-1:0] g;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero width and height act as a 1x1 frame: every dot ends a row and a frame
        program_geometry(16'h0000, 16'h0000);
        foreach (extreme_greys[k]) push_pixel(extreme_greys[k]);

        // tallest frame, 4 wide; stop inside row 2 at column 2
        program_geometry(16'd4, 16'hFFFF);
        for (int k = 0; k < 10; k++) push_pixel(clamp_greys[k]);
        // narrowing past the current column makes this pixel the last of its row
        write_reg(edh_pkg::CFG_LINE_WIDTH, 16'd2);
        push_pixel(clamp_greys[10]);
        // lowering the height below the current row makes it the last row
        write_reg(edh_pkg::CFG_FRAME_HEIGHT, 16'd1);
        push_pixel(clamp_greys[11]);
        push_pixel(clamp_greys[12]);

        // widest exact setting, then shrink to one column mid-row
        program_geometry(16'd1024, 16'd1);
        push_pixel(8'd255);
        push_pixel(8'd255);
        push_pixel(8'd0);
        write_reg(edh_pkg::CFG_LINE_WIDTH, 16'd1);
        push_pixel(8'd100);

        // random part: whole frames per geometry so every change lands at a frame start
        phase = 0;
        small_sent = 0;
        while (small_sent < RANDOM_ITEMS || phase < 4) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            if (phase == 3) begin
                // over-wide setting saturates to the full line; one row fills every column
                w_data = {5'($urandom), 11'h7FF};
                h_data = 16'd1;
            end else begin
                case ($urandom_range(9))
                    0: w_data = 16'd0;
                    1: w_data = 16'd1;
                    8, 9: w_data = 16'($urandom_range(17, 64));
                    default: w_data = 16'($urandom_range(2, 16));
                endcase
                // bits above the register width are dropped
                w_data[15:11] = 5'($urandom);
                case ($urandom_range(7))
                    0: h_data = 16'd0;
                    7: h_data = 16'($urandom_range(7, 20));
                    default: h_data = 16'($urandom_range(1, 6));
                endcase
            end
            program_geometry(w_data, h_data);

            weff = (w_data[10:0] == 0) ? 1 : (w_data[10:0] > MAX_LINE) ? MAX_LINE
                                                                       : int'(w_data[10:0]);
            heff = (h_data == 0) ? 1 : int'(h_data);
            frames = (phase == 3 || weff * heff > 200) ? 1 : $urandom_range(1, 3);
            total = weff * heff * frames;
            style = $urandom_range(3);
            base = $urandom_range(255);

            for (int n = 0; n < total; n++) begin
                case (style)
                    0: g = PIX_W'($urandom);
                    1: g = PIX_W'(base + n * 3 + $urandom_range(7));   // noisy ramp
                    2: g = extreme_greys[$urandom_range(3)];
                    default: g = PIX_W'(base);                         // flat field
                endcase
                push_pixel(g);
            end
            small_sent += total;
            phase++;
        end

        drain_dots();
        // keep the clock running to catch any stray dot
        repeat (4) @(negedge clk);

        $display("checked %0d dots over %0d random geometries plus directed edge cases",
                 dot_count, phase);
        $display("widths 1 to the full line, heights 1 to 65535, mid-frame shrinks, idle mixes");
        if (fail_count == 0)
            $display("[error_diffusion_halftone] OK");
        else
            $display("[error_diffusion_halftone] ERROR");
        $finish;
    end

endmodule
